// ===== hdl/psg_pkg.sv =====
// ============================================================================
// psg_pkg: shared types and constants for the PSG register front end
// Port and register codes, reset values, controller states and the command
// and status groups between the controller and the datapath.
// ============================================================================
package psg_pkg;

    // Bus ports.
    localparam logic [7:0] PORT_ADDR  = 8'hA0;
    localparam logic [7:0] PORT_DATA  = 8'hA1;
    localparam logic [7:0] PORT_INPUT = 8'hA2;
    localparam logic [7:0] INPUT_IDLE = 8'h3F;

    // Chip register numbers.
    localparam logic [7:0] REG_TONE_A_FINE   = 8'd0;
    localparam logic [7:0] REG_TONE_A_COARSE = 8'd1;
    localparam logic [7:0] REG_TONE_B_FINE   = 8'd2;
    localparam logic [7:0] REG_TONE_B_COARSE = 8'd3;
    localparam logic [7:0] REG_TONE_C_FINE   = 8'd4;
    localparam logic [7:0] REG_TONE_C_COARSE = 8'd5;
    localparam logic [7:0] REG_NOISE         = 8'd6;
    localparam logic [7:0] REG_MIXER         = 8'd7;
    localparam logic [7:0] REG_AMP_A         = 8'd8;
    localparam logic [7:0] REG_AMP_B         = 8'd9;
    localparam logic [7:0] REG_AMP_C         = 8'd10;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIVISOR    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MULTIPLIER = 1'b1;

    localparam logic [31:0] DIVISOR_RESET    = 32'd1000000;
    localparam logic [7:0]  MULTIPLIER_RESET = 8'd8;

    // Result kinds.
    localparam logic RESULT_VOICE = 1'b0;
    localparam logic RESULT_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_LOAD
    } psg_state_t;

    typedef struct packed {
        logic accept;
        logic start;
        logic step;
        logic emit;
    } psg_cmd_t;

    typedef struct packed {
        logic read_pend;
        logic mask_zero;
        logic sel_on;
        logic div_last;
        logic out_free;
    } psg_status_t;

endpackage

// ===== hdl/psg_ctrl.sv =====
// ============================================================================
// psg_ctrl: sequencing controller
// Accepts one bus beat, then walks the pending read or voice commands,
// running the shared divider for each voice that is on.
// ============================================================================
module psg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  psg_pkg::psg_status_t  status,
    output psg_pkg::psg_cmd_t     cmd
);
    import psg_pkg::*;

    psg_state_t state_reg;
    psg_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                priority if (status.read_pend)
                begin
                    state_next = ST_LOAD;
                end
                else if (status.mask_zero)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.sel_on)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/psg_dp.sv =====
// ============================================================================
// psg_dp: register file, divider and result register
// Holds the chip registers and configuration, tracks which channels still
// owe voice commands, divides one bit per cycle and drives the result beat.
// ============================================================================
module psg_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  psg_pkg::psg_cmd_t                    cmd,
    output psg_pkg::psg_status_t                 status,
    input  logic                                 kind,
    input  logic [7:0]                           port,
    input  logic [7:0]                           bus_data,
    input  logic                                 cfg_valid,
    input  logic [psg_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [31:0]                          cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 result_kind,
    output logic [2:0]                           voice,
    output logic                                 voice_on,
    output logic [31:0]                          frequency,
    output logic [11:0]                          volume,
    output logic [7:0]                           read_data,
    output logic                                 last
);
    import psg_pkg::*;

    // Chip and configuration registers.
    logic [7:0]  sel_reg,  sel_next;
    logic [11:0] tone_reg [3];
    logic [11:0] tone_next [3];
    logic [4:0]  noise_reg, noise_next;
    logic [5:0]  mixer_reg, mixer_next;
    logic [3:0]  amp_reg [3];
    logic [3:0]  amp_next [3];
    logic [31:0] divisor_reg, divisor_next;
    logic [7:0]  mult_reg, mult_next;

    // Work tracking.
    logic [2:0]  mask_reg, mask_next, mask_upd;
    logic        half_reg, half_next;
    logic        read_pend_reg, read_pend_next;
    logic        rd_match_reg, rd_match_next;

    // Divider.
    logic [11:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [12:0] shift_val;
    logic [12:0] trial;
    logic        fits;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic        kind_out_reg;
    logic [2:0]  voice_out_reg;
    logic        on_out_reg;
    logic [31:0] freq_out_reg;
    logic [11:0] vol_out_reg;
    logic [7:0]  rd_out_reg;
    logic        last_out_reg;

    // Current voice selection.
    logic [1:0]  cur_ch;
    logic [2:0]  cur_onehot;
    logic [2:0]  remaining;
    logic [11:0] cur_period;
    logic [2:0]  tone_dis;
    logic [2:0]  noise_dis;
    logic        cur_dis;
    logic        sel_on;
    logic [11:0] cur_vol;
    logic [2:0]  mix_diff;
    logic [1:0]  tone_ch;
    logic [1:0]  amp_ch;

    assign tone_ch = sel_reg[2:1];
    assign amp_ch  = sel_reg[1:0];

    always_comb
    begin
        priority if (mask_reg[0])
        begin
            cur_ch     = 2'd0;
            cur_onehot = 3'b001;
        end
        else if (mask_reg[1])
        begin
            cur_ch     = 2'd1;
            cur_onehot = 3'b010;
        end
        else
        begin
            cur_ch     = 2'd2;
            cur_onehot = 3'b100;
        end
    end

    assign remaining  = mask_reg & ~cur_onehot;
    assign tone_dis   = mixer_reg[2:0];
    assign noise_dis  = mixer_reg[5:3];
    assign cur_period = half_reg ? {7'd0, noise_reg} : tone_reg[cur_ch];
    assign cur_dis    = half_reg ? noise_dis[cur_ch] : tone_dis[cur_ch];
    assign sel_on     = !cur_dis && (cur_period != 12'd0);
    assign cur_vol    = 12'(amp_reg[cur_ch]) * 12'(mult_reg);
    assign mix_diff   = (mixer_reg[2:0] ^ bus_data[2:0]) | (mixer_reg[5:3] ^ bus_data[5:3]);

    // Register writes from the bus and the configuration port.
    always_comb
    begin
        sel_next     = sel_reg;
        tone_next    = tone_reg;
        noise_next   = noise_reg;
        mixer_next   = mixer_reg;
        amp_next     = amp_reg;
        divisor_next = divisor_reg;
        mult_next    = mult_reg;
        mask_upd     = 3'b000;
        if (cmd.accept && !kind)
        begin
            if (port == PORT_ADDR)
            begin
                sel_next = bus_data;
            end
            else if (port == PORT_DATA)
            begin
                unique case (sel_reg)
                    REG_TONE_A_FINE, REG_TONE_B_FINE, REG_TONE_C_FINE:
                    begin
                        tone_next[tone_ch] = {tone_reg[tone_ch][11:8], bus_data};
                        mask_upd           = 3'b001 << tone_ch;
                    end
                    REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE:
                    begin
                        tone_next[tone_ch] = {bus_data[3:0], tone_reg[tone_ch][7:0]};
                        mask_upd           = 3'b001 << tone_ch;
                    end
                    REG_NOISE:
                    begin
                        noise_next = bus_data[4:0];
                        mask_upd   = 3'b111;
                    end
                    REG_MIXER:
                    begin
                        mixer_next = bus_data[5:0];
                        mask_upd   = mix_diff;
                    end
                    REG_AMP_A, REG_AMP_B, REG_AMP_C:
                    begin
                        amp_next[amp_ch] = bus_data[3:0];
                        mask_upd         = 3'b001 << amp_ch;
                    end
                    default:
                    begin
                        mask_upd = 3'b000;
                    end
                endcase
            end
        end
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DIVISOR:    divisor_next = cfg_data;
                CFG_MULTIPLIER: mult_next    = cfg_data[7:0];
                default:        divisor_next = divisor_reg;
            endcase
        end
    end

    // Pending work: the read result, or tone then noise for each marked channel.
    always_comb
    begin
        mask_next      = mask_reg;
        half_next      = half_reg;
        read_pend_next = read_pend_reg;
        rd_match_next  = rd_match_reg;
        if (cmd.accept)
        begin
            mask_next      = kind ? 3'b000 : mask_upd;
            half_next      = 1'b0;
            read_pend_next = kind;
            rd_match_next  = (port == PORT_INPUT);
        end
        else if (cmd.emit)
        begin
            priority if (read_pend_reg)
            begin
                read_pend_next = 1'b0;
            end
            else if (half_reg)
            begin
                mask_next = remaining;
                half_next = 1'b0;
            end
            else
            begin
                half_next = 1'b1;
            end
        end
    end

    // Restoring division, one quotient bit per cycle.
    assign shift_val = {rem_reg, quo_reg[31]};
    assign trial     = shift_val - {1'b0, cur_period};
    assign fits      = (shift_val >= {1'b0, cur_period});

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (cmd.start)
        begin
            rem_next = 12'd0;
            quo_next = divisor_reg;
            cnt_next = 5'd0;
        end
        else if (cmd.step)
        begin
            rem_next = fits ? trial[11:0] : shift_val[11:0];
            quo_next = {quo_reg[30:0], fits};
            cnt_next = cnt_reg + 5'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= '0;
            tone_reg      <= '{default: '0};
            noise_reg     <= '0;
            mixer_reg     <= '0;
            amp_reg       <= '{default: '0};
            divisor_reg   <= DIVISOR_RESET;
            mult_reg      <= MULTIPLIER_RESET;
            mask_reg      <= '0;
            half_reg      <= 1'b0;
            read_pend_reg <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg       <= sel_next;
            tone_reg      <= tone_next;
            noise_reg     <= noise_next;
            mixer_reg     <= mixer_next;
            amp_reg       <= amp_next;
            divisor_reg   <= divisor_next;
            mult_reg      <= mult_next;
            mask_reg      <= mask_next;
            half_reg      <= half_next;
            read_pend_reg <= read_pend_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_match_reg <= rd_match_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        if (cmd.emit)
        begin
            if (read_pend_reg)
            begin
                kind_out_reg  <= RESULT_READ;
                voice_out_reg <= 3'd0;
                on_out_reg    <= 1'b0;
                freq_out_reg  <= 32'd0;
                vol_out_reg   <= 12'd0;
                rd_out_reg    <= rd_match_reg ? INPUT_IDLE : 8'd0;
                last_out_reg  <= 1'b1;
            end
            else
            begin
                kind_out_reg  <= RESULT_VOICE;
                voice_out_reg <= half_reg ? (3'd3 + {1'b0, cur_ch}) : {1'b0, cur_ch};
                on_out_reg    <= sel_on;
                freq_out_reg  <= sel_on ? quo_reg : 32'd0;
                vol_out_reg   <= sel_on ? cur_vol : 12'd0;
                rd_out_reg    <= 8'd0;
                last_out_reg  <= half_reg && (remaining == 3'b000);
            end
        end
    end

    assign status.read_pend = read_pend_reg;
    assign status.mask_zero = (mask_reg == 3'b000);
    assign status.sel_on    = sel_on;
    assign status.div_last  = &cnt_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_out_reg;
    assign voice       = voice_out_reg;
    assign voice_on    = on_out_reg;
    assign frequency   = freq_out_reg;
    assign volume      = vol_out_reg;
    assign read_data   = rd_out_reg;
    assign last        = last_out_reg;

endmodule

// ===== hdl/psg_register_to_voice_commands.sv =====
// ============================================================================
// psg_register_to_voice_commands: PSG register front end, top level
// Turns CPU bus beats aimed at a three-channel sound chip into voice commands.
// ============================================================================
// Usage. The input channel (in_valid, in_stall, kind, port, bus_data) takes
// one bus access per beat. A read returns one result beat carrying read_data.
// A write to the address port latches a register number and produces nothing;
// a write to the data port updates a chip register and then produces a tone
// beat and a noise beat for every channel that the write touched, channels in
// order A, B, C. The final beat caused by an access has last set.
// Timing. A read, or a write with no result, keeps the input stalled until the
// sequencer is back in idle. A voice that is on takes longer than one that is
// off, because its frequency comes from a shared radix-2 divider that retires
// one quotient bit per cycle. A noise-period write yields beats for all six
// voices. The block handles one access at a time and holds in_stall high
// until every result of that access has been loaded into the output register.
// Back-pressure. When out_stall is high the result beat holds; the sequencer
// waits before loading the next beat. The configuration port (cfg_valid,
// cfg_ready, cfg_index, cfg_data) is always ready and should be written only
// while the block is idle.
// Reset. rst_n clears all chip registers to zero and restores the divisor
// (1000000) and multiplier (8) defaults; no result is pending after reset.
// ============================================================================
module psg_register_to_voice_commands (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             kind,
    input  logic [7:0]                       port,
    input  logic [7:0]                       bus_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [psg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [31:0]                      cfg_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             result_kind,
    output logic [2:0]                       voice,
    output logic                             voice_on,
    output logic [31:0]                      frequency,
    output logic [11:0]                      volume,
    output logic [7:0]                       read_data,
    output logic                             last
);
    import psg_pkg::*;

    psg_cmd_t    cmd;
    psg_status_t status;

    // Configuration registers take any beat, so the port never pushes back.
    assign cfg_ready = 1'b1;

    // The controller owns the input handshake and issues one command per step.
    psg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the chip and work registers, the divider and the output register.
    psg_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .kind        (kind),
        .port        (port),
        .bus_data    (bus_data),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .voice       (voice),
        .voice_on    (voice_on),
        .frequency   (frequency),
        .volume      (volume),
        .read_data   (read_data),
        .last        (last)
    );

endmodule

// ===== hdl/psg_checker.sv =====
// ============================================================================
// psg_checker: port-level checks for the PSG front end
// Watches the top-level ports and flags result beats that break the rules.
// ============================================================================
module psg_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic                             result_kind,
    input logic [2:0]                       voice,
    input logic                             voice_on,
    input logic [31:0]                      frequency,
    input logic [11:0]                      volume,
    input logic [7:0]                       read_data,
    input logic                             last
);
    import psg_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frequency) && $stable(voice)
            && $stable(last))
        else $error("stalled result beat changed");

    // One access at a time: right after a beat is taken the input stalls.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accepted beat");

    // A read result is always the single, final beat and carries no voice.
    a_read_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == RESULT_READ) |->
            last && (voice == 3'd0) && !voice_on && (frequency == 32'd0))
        else $error("malformed read result");

    // A silenced voice carries no frequency or volume.
    a_voice_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == RESULT_VOICE) && !voice_on |->
            (frequency == 32'd0) && (volume == 12'd0) && (read_data == 8'd0))
        else $error("silenced voice carries data");

    // Voice numbers stop at noise C.
    a_voice_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == RESULT_VOICE) |-> (voice <= 3'd5))
        else $error("voice index out of range");

endmodule

bind psg_register_to_voice_commands psg_checker u_psg_checker (.*);
